/* sv/printable_string_extractor_assert.svh */
`ifndef PRINTABLE_STRING_EXTRACTOR_ASSERT_SVH
`define PRINTABLE_STRING_EXTRACTOR_ASSERT_SVH

// same-cycle implication, held off while in reset
`define PSE_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off while in reset
`define PSE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/pse_pkg.sv */
package pse_pkg;

  localparam int MaxMinLengthDefault = 16;
  // upper end of the prefix depth range, sizes the command fields
  localparam int MaxMinLengthTop     = 64;
  localparam int CmdAddrW            = $clog2(MaxMinLengthTop);

  localparam int       CfgW           = 5;
  localparam logic [CfgW-1:0] MinLengthReset = 5'd4;
  localparam int       RunCap         = 31;
  localparam logic [7:0] PrintLo      = 8'd32;
  localparam logic [7:0] PrintHi      = 8'd126;
  localparam int       QueueDepth     = 4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } pse_in_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       char_valid;
    logic       string_start;
    logic       string_end;
    logic       last_of_burst;
  } pse_out_t;

  // request from the front to the back, one per byte that needs any
  typedef struct packed {
    logic [7:0]          data_byte;
    logic                wr_en;
    logic [CmdAddrW-1:0] wr_addr;
    logic                burst_en;
    logic                pass_en;
    logic                end_en;
  } pse_cmd_t;

endpackage

/* sv/pse_front.sv */
module pse_front
  import pse_pkg::*;
#(
  parameter int MAX_MIN_LENGTH = MaxMinLengthDefault
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [CfgW-1:0] cfg_data,
  input  logic            byte_valid,
  output logic            byte_ready,
  input  pse_in_t         byte_data,
  output logic            cmd_valid,
  input  logic            cmd_ready,
  output pse_cmd_t        cmd_data
);

  localparam int RlW = ($clog2(MAX_MIN_LENGTH + 1) > CfgW) ?
                       $clog2(MAX_MIN_LENGTH + 1) : CfgW;

  logic [CfgW-1:0] min_length;
  logic [RlW-1:0]  run_length;
  logic [RlW-1:0]  run_length_next;
  logic [RlW-1:0]  cfg_ext;
  logic [RlW-1:0]  thresh;
  logic [RlW-1:0]  rl_inc;
  logic            printable;
  logic            closing;
  logic            accept;
  pse_cmd_t        cmd;

  assign cfg_ready = 1'b1;
  assign cfg_ext   = RlW'(min_length);

  always_comb begin
    if (cfg_ext == '0) begin
      thresh = RlW'(1);
    end else if (cfg_ext > RlW'(MAX_MIN_LENGTH)) begin
      thresh = RlW'(MAX_MIN_LENGTH);
    end else begin
      thresh = cfg_ext;
    end
  end

  assign printable = (byte_data.data_byte >= PrintLo) && (byte_data.data_byte <= PrintHi);
  assign rl_inc    = run_length + 1'b1;

  always_comb begin
    cmd           = '0;
    cmd.data_byte = byte_data.data_byte;
    run_length_next = run_length;
    closing       = 1'b1;
    if (printable) begin
      closing = byte_data.end_of_buffer;
      if (run_length < thresh) begin
        // still filling the prefix
        cmd.wr_en       = 1'b1;
        cmd.wr_addr     = CmdAddrW'(run_length);
        cmd.burst_en    = (rl_inc == thresh);
        run_length_next = rl_inc;
      end else begin
        cmd.pass_en = 1'b1;
        if (run_length < RlW'(RunCap)) begin
          run_length_next = rl_inc;
        end
      end
    end
    if (closing) begin
      cmd.end_en      = (run_length_next >= thresh);
      run_length_next = '0;
    end
  end

  assign byte_ready = cmd_ready;
  assign accept     = byte_valid && byte_ready;
  assign cmd_data   = cmd;
  assign cmd_valid  = byte_valid && (cmd.wr_en || cmd.burst_en || cmd.pass_en || cmd.end_en);

  always_ff @(posedge clk) begin
    if (rst) begin
      min_length <= MinLengthReset;
      run_length <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        min_length <= cfg_data;
      end
      if (accept) begin
        run_length <= run_length_next;
      end
    end
  end

endmodule

/* sv/pse_queue.sv */
module pse_queue
  import pse_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push_valid,
  output logic     push_ready,
  input  pse_cmd_t push_data,
  output logic     pop_valid,
  input  logic     pop_ready,
  output pse_cmd_t pop_data
);

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);

  pse_cmd_t        slots [QueueDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (count != CntW'(QueueDepth));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* sv/pse_back.sv */
module pse_back
  import pse_pkg::*;
#(
  parameter int MAX_MIN_LENGTH = MaxMinLengthDefault
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     cmd_valid,
  output logic     cmd_ready,
  input  pse_cmd_t cmd_data,
  output logic     result_valid,
  input  logic     result_ready,
  output pse_out_t result_data
);

  localparam int AddrW = (MAX_MIN_LENGTH > 1) ? $clog2(MAX_MIN_LENGTH) : 1;

  logic [7:0]       prefix_buffer [MAX_MIN_LENGTH];
  logic             burst_pend;
  logic             pass_pend;
  logic             end_pend;
  logic [AddrW-1:0] idx;
  logic [AddrW-1:0] last_idx;
  logic [7:0]       cur_byte;
  logic             busy;
  logic             emit;
  logic             fin;
  logic             pop;
  pse_out_t         res;

  assign busy = burst_pend || pass_pend || end_pend;
  assign emit = busy && (!result_valid || result_ready);

  always_comb begin
    res = '0;
    fin = 1'b0;
    if (burst_pend) begin
      res.char_out     = prefix_buffer[idx];
      res.char_valid   = 1'b1;
      res.string_start = (idx == '0);
      fin              = (idx == last_idx) && !end_pend;
    end else if (pass_pend) begin
      res.char_out   = cur_byte;
      res.char_valid = 1'b1;
      fin            = !end_pend;
    end else begin
      res.string_end = 1'b1;
      fin            = 1'b1;
    end
    res.last_of_burst = fin;
  end

  // next request is taken once the current one hands over its final result
  assign pop       = cmd_valid && (!busy || (emit && fin));
  assign cmd_ready = pop;

  always_ff @(posedge clk) begin
    if (pop && cmd_data.wr_en) begin
      prefix_buffer[cmd_data.wr_addr[AddrW-1:0]] <= cmd_data.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result_data <= res;
    end
    if (pop) begin
      idx      <= '0;
      last_idx <= cmd_data.wr_addr[AddrW-1:0];
      cur_byte <= cmd_data.data_byte;
    end else if (emit && burst_pend) begin
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      burst_pend   <= 1'b0;
      pass_pend    <= 1'b0;
      end_pend     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (emit) begin
        result_valid <= 1'b1;
        if (burst_pend) begin
          if (idx == last_idx) begin
            burst_pend <= 1'b0;
          end
        end else if (pass_pend) begin
          pass_pend <= 1'b0;
        end else begin
          end_pend <= 1'b0;
        end
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      if (pop) begin
        burst_pend <= cmd_data.burst_en;
        pass_pend  <= cmd_data.pass_en;
        end_pend   <= cmd_data.end_en;
      end
    end
  end

endmodule

/* sv/printable_string_extractor.sv */
// Printable string extractor: scans a byte stream for runs of printable ASCII
// (32 to 126) at least min_length long (1 to MAX_MIN_LENGTH, reset 4). The
// front takes one byte per cycle while the request queue has room and tracks
// the run; the back writes the prefix store and sends results, one per cycle
// while the receiver takes them, through an output register. A run reaching
// its threshold gives a burst of min_length results, later characters one
// result each, a qualifying run closes with an end marker. A byte that only
// fills the prefix is one back request with no result, a byte with results
// causes up to MAX_MIN_LENGTH + 1 of them, and a byte that writes nothing and
// causes nothing sends no request; a four-entry request queue between front
// and back absorbs bursts, and the input stalls only when that queue is full.
module printable_string_extractor
  import pse_pkg::*;
#(
  parameter int MAX_MIN_LENGTH = MaxMinLengthDefault
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [CfgW-1:0] cfg_data,
  input  logic            byte_valid,
  output logic            byte_ready,
  input  pse_in_t         byte_data,
  output logic            result_valid,
  input  logic            result_ready,
  output pse_out_t        result_data
);

  logic     fq_valid;
  logic     fq_ready;
  pse_cmd_t fq_data;
  logic     qb_valid;
  logic     qb_ready;
  pse_cmd_t qb_data;

  pse_front #(
    .MAX_MIN_LENGTH(MAX_MIN_LENGTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .byte_valid(byte_valid),
    .byte_ready(byte_ready),
    .byte_data (byte_data),
    .cmd_valid (fq_valid),
    .cmd_ready (fq_ready),
    .cmd_data  (fq_data)
  );

  pse_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(fq_valid),
    .push_ready(fq_ready),
    .push_data (fq_data),
    .pop_valid (qb_valid),
    .pop_ready (qb_ready),
    .pop_data  (qb_data)
  );

  pse_back #(
    .MAX_MIN_LENGTH(MAX_MIN_LENGTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (qb_valid),
    .cmd_ready   (qb_ready),
    .cmd_data    (qb_data),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result_data (result_data)
  );

endmodule

/* sv/pse_checker.sv */
`include "printable_string_extractor_assert.svh"

module pse_checker
  import pse_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     result_valid,
  input logic     result_ready,
  input pse_out_t result_data
);

  logic stalled;
  logic is_end;
  logic is_start;
  logic end_shape_ok;
  logic one_kind;
  logic start_ok;

  assign stalled      = result_valid && !result_ready;
  assign is_end       = result_valid && result_data.string_end;
  assign is_start     = result_valid && result_data.string_start;
  assign end_shape_ok = (result_data.char_out == 8'd0) && !result_data.string_start &&
                        result_data.last_of_burst;
  assign one_kind     = result_data.char_valid != result_data.string_end;
  assign start_ok     = result_data.char_valid && (result_data.char_out >= PrintLo) &&
                        (result_data.char_out <= PrintHi);

  `PSE_ASSERT_NEXT(a_hold, clk, rst, stalled, result_valid && $stable(result_data), "result not held")
  `PSE_ASSERT_IMPLY(a_end_shape, clk, rst, is_end, end_shape_ok, "malformed end marker")
  `PSE_ASSERT_IMPLY(a_char_or_end, clk, rst, result_valid, one_kind, "neither char nor end")
  `PSE_ASSERT_IMPLY(a_start_is_char, clk, rst, is_start, start_ok, "bad string start")

endmodule

bind printable_string_extractor pse_checker u_pse_checker (
  .clk         (clk),
  .rst         (rst),
  .result_valid(result_valid),
  .result_ready(result_ready),
  .result_data (result_data)
);

/* bench/tb_printable_string_extractor.sv */
`timescale 1ns / 1ps

module tb_printable_string_extractor;
  import pse_pkg::*;

  localparam logic [4:0] MaxLen = 5'(MaxMinLengthDefault);
  localparam int SettleCycles = 16;
  localparam int HoldCycles = 300;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [CfgW-1:0] cfg_data = '0;
  logic            byte_valid = 1'b0;
  logic            byte_ready;
  pse_in_t         byte_data = '0;
  logic            result_valid;
  logic            result_ready = 1'b0;
  pse_out_t        result_data;

  // predictor state
  logic [7:0] prefix_mem [MaxMinLengthDefault];
  logic [4:0] run_len = '0;
  logic [4:0] min_len = MinLengthReset;
  pse_out_t   expected_results [$];

  int errors = 0;
  int bytes_sent = 0;
  int results_seen = 0;
  int strings_closed = 0;
  int threshold_writes = 0;

  // sender pacing
  int burst_left = 0;
  bit no_idle = 1'b0;

  // receiver pacing
  int unsigned rx_cycle = 0;
  int hold_requests = 0;
  int holds_taken = 0;
  int hold_left = 0;

  always #2 clk = ~clk;

  printable_string_extractor #(
    .MAX_MIN_LENGTH(MaxMinLengthDefault)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .byte_valid  (byte_valid),
    .byte_ready  (byte_ready),
    .byte_data   (byte_data),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result_data (result_data)
  );

  task automatic predict_results(input pse_in_t item);
    pse_out_t   burst [MaxMinLengthDefault + 1];
    logic [4:0] eff;
    logic       closing;
    int         n;
    begin
      n = 0;
      eff = (min_len == 0) ? 5'd1 : ((min_len > MaxLen) ? MaxLen : min_len);
      if (item.data_byte >= PrintLo && item.data_byte <= PrintHi) begin
        if (run_len < eff) begin
          prefix_mem[run_len[3:0]] = item.data_byte;
          run_len = run_len + 1'b1;
          // threshold reached: the whole prefix goes out at once
          if (run_len == eff) begin
            for (int i = 0; i < eff; i++) begin
              burst[n] = '{prefix_mem[4'(i)], 1'b1, (i == 0), 1'b0, 1'b0};
              n++;
            end
          end
        end else begin
          burst[n] = '{item.data_byte, 1'b1, 1'b0, 1'b0, 1'b0};
          n++;
          if (run_len < RunCap) run_len = run_len + 1'b1;
        end
        closing = item.end_of_buffer;
      end else begin
        closing = 1'b1;
      end
      if (closing) begin
        if (run_len >= eff) begin
          burst[n] = '{8'd0, 1'b0, 1'b0, 1'b1, 1'b0};
          n++;
        end
        run_len = '0;
      end
      if (n > 0) burst[n - 1].last_of_burst = 1'b1;
      for (int i = 0; i < n; i++) expected_results = {expected_results, burst[i]};
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic eob);
    int gap;
    begin
      gap = 0;
      if (!no_idle) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          gap = $urandom_range(0, 5);
        end else begin
          burst_left--;
        end
      end
      if (gap > 0) begin
        byte_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      byte_valid <= 1'b1;
      byte_data <= '{b, eob};
      do @(posedge clk); while (!byte_ready);
      predict_results('{b, eob});
      bytes_sent++;
    end
  endtask

  task automatic send_text(input string s, input bit eob_last);
    begin
      for (int i = 0; i < s.len(); i++) send_byte(s[i], eob_last && (i == s.len() - 1));
    end
  endtask

  function automatic logic [7:0] rand_control();
    int v;
    begin
      v = $urandom_range(0, 160);
      return (v < 32) ? v[7:0] : 8'(v + 95);
    end
  endfunction

  // sender pause: nothing left in flight, then a settle margin for bytes with no result
  task automatic wait_for_results();
    begin
      byte_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clk);
      repeat (SettleCycles) @(posedge clk);
    end
  endtask

  task automatic write_min_length(input logic [4:0] v);
    begin
      wait_for_results();
      cfg_valid <= 1'b1;
      cfg_data <= v;
      do @(posedge clk); while (!cfg_ready);
      cfg_valid <= 1'b0;
      min_len = v;
      threshold_writes++;
    end
  endtask

  task automatic test_default_threshold();
    begin
      send_text("ab", 1'b0);
      send_byte(8'd31, 1'b0);            // short run dropped
      send_text(" ~Zq", 1'b1);           // printable range edges, end on last char
      send_text("wxyz!", 1'b0);
      send_byte(8'hFF, 1'b1);            // end flag on a control byte
      send_byte(8'd127, 1'b0);           // no run open
    end
  endtask

  task automatic test_threshold_change_mid_run();
    begin
      write_min_length(5'd8);
      send_text("Hello", 1'b0);
      write_min_length(5'd3);            // run already past new threshold
      send_text("W", 1'b0);
      send_byte(8'h00, 1'b1);
      send_text("ab", 1'b0);
      write_min_length(5'd6);            // buffering carries on from the old entries
      send_text("cdef", 1'b0);
      send_byte(8'd127, 1'b0);
    end
  endtask

  task automatic test_random_strings(input logic [4:0] threshold, input int n_items,
                                     input int first_len, input bit squeeze);
    int  target;
    int  len;
    bit  eob_last;
    begin
      write_min_length(threshold);
      if (squeeze) begin
        no_idle = 1'b1;
        hold_requests <= hold_requests + 1;
      end
      target = bytes_sent + n_items;
      for (int i = 0; i < first_len; i++)
        send_byte(8'($urandom_range(32, 126)), i == first_len - 1);
      while (bytes_sent < target) begin
        if ($urandom_range(0, 9) < 7) begin
          if ($urandom_range(0, 7) == 0) len = $urandom_range(28, 40);
          else len = $urandom_range(0, threshold + 4);
          eob_last = ($urandom_range(0, 3) == 0) && (len > 0);
          for (int i = 0; i < len; i++)
            send_byte(8'($urandom_range(32, 126)), eob_last && (i == len - 1));
          if (!eob_last) send_byte(rand_control(), 1'($urandom_range(0, 1)));
        end else begin
          send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
      end
      send_byte(rand_control(), 1'b1);   // leave no run open across a threshold change
      no_idle = 1'b0;
    end
  endtask

  // receiver: own stall pattern, plus a long hold-off on request
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rst) begin
      result_ready <= 1'b0;
    end else if (hold_left > 0) begin
      result_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_taken != hold_requests) begin
      result_ready <= 1'b0;
      holds_taken <= holds_taken + 1;
      hold_left <= HoldCycles;
    end else begin
      case (rx_cycle[7:6])
        2'd0: result_ready <= 1'b1;
        2'd1: result_ready <= ($urandom_range(0, 3) != 0);
        2'd2: result_ready <= (rx_cycle[2:0] < 3'd5);
        default: result_ready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  task automatic report_field(input string field, input int want, input int got);
    begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : result_check
    pse_out_t want;
    if (!rst && result_valid && result_ready) begin
      results_seen++;
      if (result_data.string_end) strings_closed++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, result_data);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (result_data.char_out !== want.char_out)
          report_field("char_out", int'(want.char_out), int'(result_data.char_out));
        if (result_data.char_valid !== want.char_valid)
          report_field("char_valid", int'(want.char_valid), int'(result_data.char_valid));
        if (result_data.string_start !== want.string_start)
          report_field("string_start", int'(want.string_start),
                       int'(result_data.string_start));
        if (result_data.string_end !== want.string_end)
          report_field("string_end", int'(want.string_end), int'(result_data.string_end));
        if (result_data.last_of_burst !== want.last_of_burst)
          report_field("last_of_burst", int'(want.last_of_burst),
                       int'(result_data.last_of_burst));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("%0t: timed out with %0d results outstanding", $time, expected_results.size());
    $display("** printable_string_extractor: FAILED **");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_threshold();
    test_threshold_change_mid_run();
    test_random_strings(5'd16, 36, 16, 1'b0);
    test_random_strings(5'd1, 36, 35, 1'b0);
    test_random_strings(5'($urandom_range(2, 15)), 30, 6, 1'b1);
    test_random_strings(5'($urandom_range(2, 15)), 28, 3, 1'b0);
    test_random_strings(MinLengthReset, 20, 4, 1'b0);
    wait_for_results();
    $display("run covered %0d bytes and %0d results, %0d strings closed,", bytes_sent,
             results_seen, strings_closed);
    $display("over %0d threshold writes from 1 to 16 with a long output hold-off",
             threshold_writes);
    if (errors == 0) begin
      $display("** printable_string_extractor: PASSED **");
    end else begin
      $display("** printable_string_extractor: FAILED **");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/pse_pkg.sv
sv/pse_front.sv
sv/pse_queue.sv
sv/pse_back.sv
sv/printable_string_extractor.sv
sv/pse_checker.sv
bench/tb_printable_string_extractor.sv
